FILE: rtl/markov_transition_sampler_defines.svh
// Assertion macros used by the checker of the transition sampler.
`ifndef MARKOV_TRANSITION_SAMPLER_DEFINES_SVH
`define MARKOV_TRANSITION_SAMPLER_DEFINES_SVH

// Checked at every clock edge, reset included.
`define MTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the active-low reset is released.
`define MTS_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/mts_pkg.sv
// Package with the constants, codes and payload types of the transition sampler.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

    localparam int MAX_STATES     = 64;
    localparam int COUNT_BITS     = 16;
    localparam int RANDOM_BITS    = 16;
    localparam int STATE_BITS     = $clog2(MAX_STATES);
    localparam int ACTIVE_BITS    = 7;
    localparam int PAIR_DEPTH     = MAX_STATES * MAX_STATES;
    localparam int PAIR_ADDR_BITS = 2 * STATE_BITS;
    localparam int TOTAL_BITS     = COUNT_BITS + STATE_BITS;
    localparam int PROD_BITS      = TOTAL_BITS + RANDOM_BITS;
    localparam int FROM_BITS      = 6;
    localparam int RVAL_BITS      = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 7'd64;

    // Register index taken from paddr[2].
    localparam logic REG_ACTIVE_STATES = 1'b0;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic                 func;
        logic [FROM_BITS-1:0] from_state;
        logic [FROM_BITS-1:0] to_state;
        logic [RVAL_BITS-1:0] random_value;
    } t_cmd;

    typedef struct packed {
        logic [FROM_BITS-1:0] next_state;
        logic [1:0]           status;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/markov_transition_sampler.sv
// Top level: configuration port, count memories and the sequencer that drives them.
// An index out of range is answered straight from the idle state; a record passes through
// S_REC, an empty row S_ROW, and a sample S_ROW and then S_WALK (one column per cycle).
// One item at a time; the next start is taken in the cycle that shows the result strobe.
// The sample rate is set by the walk through the row, one count-memory read per cycle.
// After reset a clearing pass walks every count address and zeroes both memories while busy stays high.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module markov_transition_sampler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire mts_pkg::t_cmd                       i_cmd,
    output logic                                     o_valid,
    output mts_pkg::t_result                         o_result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mts_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [mts_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [mts_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready
);

    logic [mts_pkg::ACTIVE_BITS-1:0] r_active_states;
    logic                            cfg_write;

    logic                                 pair_we;
    logic [mts_pkg::PAIR_ADDR_BITS-1:0]   pair_waddr;
    logic [mts_pkg::COUNT_BITS-1:0]       pair_wdata;
    logic [mts_pkg::PAIR_ADDR_BITS-1:0]   pair_raddr;
    logic [mts_pkg::COUNT_BITS-1:0]       pair_rdata;
    logic                                 row_we;
    logic [mts_pkg::STATE_BITS-1:0]       row_waddr;
    logic [mts_pkg::TOTAL_BITS-1:0]       row_wdata;
    logic [mts_pkg::STATE_BITS-1:0]       row_raddr;
    logic [mts_pkg::TOTAL_BITS-1:0]       row_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_states <= mts_pkg::ACTIVE_RESET;
        end else if (cfg_write && (paddr[2] == mts_pkg::REG_ACTIVE_STATES)) begin
            r_active_states <= pwdata[mts_pkg::ACTIVE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mts_pkg::REG_ACTIVE_STATES) begin
            prdata = mts_pkg::APB_DATA_BITS'(r_active_states);
        end
    end

    mts_ram #(
        .WIDTH (mts_pkg::COUNT_BITS),
        .DEPTH (mts_pkg::PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (pair_raddr),
        .o_rdata (pair_rdata)
    );

    mts_ram #(
        .WIDTH (mts_pkg::TOTAL_BITS),
        .DEPTH (mts_pkg::MAX_STATES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    mts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_cmd           (i_cmd),
        .i_active_states (r_active_states),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_result        (o_result),
        .o_pair_we       (pair_we),
        .o_pair_waddr    (pair_waddr),
        .o_pair_wdata    (pair_wdata),
        .o_pair_raddr    (pair_raddr),
        .i_pair_rdata    (pair_rdata),
        .o_row_we        (row_we),
        .o_row_waddr     (row_waddr),
        .o_row_wdata     (row_wdata),
        .o_row_raddr     (row_raddr),
        .i_row_rdata     (row_rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/mts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/mts_ctrl.sv
// Sequencer that clears, updates and walks the count and row-total memories.
`timescale 1ns / 1ps
`default_nettype none
module mts_ctrl (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire mts_pkg::t_cmd                        i_cmd,
    input  wire logic [mts_pkg::ACTIVE_BITS-1:0]      i_active_states,
    output logic                                      o_busy,
    output logic                                      o_valid,
    output mts_pkg::t_result                          o_result,
    output logic                                      o_pair_we,
    output logic      [mts_pkg::PAIR_ADDR_BITS-1:0]   o_pair_waddr,
    output logic      [mts_pkg::COUNT_BITS-1:0]       o_pair_wdata,
    output logic      [mts_pkg::PAIR_ADDR_BITS-1:0]   o_pair_raddr,
    input  wire logic [mts_pkg::COUNT_BITS-1:0]       i_pair_rdata,
    output logic                                      o_row_we,
    output logic      [mts_pkg::STATE_BITS-1:0]       o_row_waddr,
    output logic      [mts_pkg::TOTAL_BITS-1:0]       o_row_wdata,
    output logic      [mts_pkg::STATE_BITS-1:0]       o_row_raddr,
    input  wire logic [mts_pkg::TOTAL_BITS-1:0]       i_row_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REC,
        S_ROW,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic [mts_pkg::PAIR_ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [mts_pkg::STATE_BITS-1:0]     r_from, n_from;
    logic [mts_pkg::STATE_BITS-1:0]     r_to, n_to;
    logic [mts_pkg::RANDOM_BITS-1:0]    r_rnd, n_rnd;
    logic [mts_pkg::STATE_BITS-1:0]     r_j, n_j;
    logic [mts_pkg::TOTAL_BITS-1:0]     r_sum, n_sum;
    logic [mts_pkg::TOTAL_BITS-1:0]     r_target, n_target;
    logic                               r_valid, n_valid;
    mts_pkg::t_result                   r_result, n_result;

    logic [mts_pkg::ACTIVE_BITS-1:0] live;
    logic                            range_err;
    logic [mts_pkg::PROD_BITS-1:0]   prod;
    logic [mts_pkg::TOTAL_BITS-1:0]  sum_next;

    assign live = (i_active_states > mts_pkg::ACTIVE_BITS'(mts_pkg::MAX_STATES))
                ? mts_pkg::ACTIVE_BITS'(mts_pkg::MAX_STATES) : i_active_states;

    assign range_err = ({1'b0, i_cmd.from_state} >= live)
                    || ((i_cmd.func == mts_pkg::FUNC_RECORD) && ({1'b0, i_cmd.to_state} >= live));

    // Scaled draw: floor(random * total / 2^RANDOM_BITS), registered before the walk.
    assign prod = mts_pkg::PROD_BITS'(r_rnd) * mts_pkg::PROD_BITS'(i_row_rdata);

    assign sum_next = r_sum + mts_pkg::TOTAL_BITS'(i_pair_rdata);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_from     = r_from;
        n_to       = r_to;
        n_rnd      = r_rnd;
        n_j        = r_j;
        n_sum      = r_sum;
        n_target   = r_target;
        n_valid    = 1'b0;
        n_result   = r_result;

        o_pair_we    = 1'b0;
        o_pair_waddr = r_clr_addr;
        o_pair_wdata = '0;
        o_row_we     = 1'b0;
        o_row_waddr  = r_clr_addr[mts_pkg::STATE_BITS-1:0];
        o_row_wdata  = '0;
        o_pair_raddr = {r_from, r_j + mts_pkg::STATE_BITS'(1)};
        o_row_raddr  = r_from;

        unique case (r_state)
            S_CLEAR: begin
                o_pair_we  = 1'b1;
                o_row_we   = (r_clr_addr[mts_pkg::PAIR_ADDR_BITS-1:mts_pkg::STATE_BITS] == '0);
                n_clr_addr = r_clr_addr + mts_pkg::PAIR_ADDR_BITS'(1);
                if (r_clr_addr == {mts_pkg::PAIR_ADDR_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_pair_raddr = {i_cmd.from_state, i_cmd.to_state};
                o_row_raddr  = i_cmd.from_state;
                if (i_start) begin
                    n_from = i_cmd.from_state;
                    n_to   = i_cmd.to_state;
                    n_rnd  = i_cmd.random_value[mts_pkg::RANDOM_BITS-1:0];
                    if (range_err) begin
                        n_valid             = 1'b1;
                        n_result.next_state = '0;
                        n_result.status     = mts_pkg::STATUS_RANGE;
                    end else if (i_cmd.func == mts_pkg::FUNC_RECORD) begin
                        n_state = S_REC;
                    end else begin
                        n_state = S_ROW;
                    end
                end
            end
            S_REC: begin
                // A saturated count leaves both the count and the row total alone.
                o_pair_waddr = {r_from, r_to};
                o_pair_wdata = i_pair_rdata + mts_pkg::COUNT_BITS'(1);
                o_row_waddr  = r_from;
                o_row_wdata  = i_row_rdata + mts_pkg::TOTAL_BITS'(1);
                if (i_pair_rdata != mts_pkg::CNT_MAX) begin
                    o_pair_we = 1'b1;
                    o_row_we  = 1'b1;
                end
                n_valid             = 1'b1;
                n_result.next_state = '0;
                n_result.status     = mts_pkg::STATUS_OK;
                n_state             = S_IDLE;
            end
            S_ROW: begin
                o_pair_raddr = {r_from, mts_pkg::STATE_BITS'(0)};
                n_j          = '0;
                n_sum        = '0;
                if (i_row_rdata == '0) begin
                    n_valid             = 1'b1;
                    n_result.next_state = '0;
                    n_result.status     = mts_pkg::STATUS_EMPTY;
                    n_state             = S_IDLE;
                end else begin
                    n_target = prod[mts_pkg::PROD_BITS-1:mts_pkg::RANDOM_BITS];
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (sum_next > r_target) begin
                    n_valid             = 1'b1;
                    n_result.next_state = r_j;
                    n_result.status     = mts_pkg::STATUS_OK;
                    n_state             = S_IDLE;
                end else if ({1'b0, r_j} == live - mts_pkg::ACTIVE_BITS'(1)) begin
                    // Remaining mass sits in columns beyond the active states.
                    n_valid             = 1'b1;
                    n_result.next_state = '0;
                    n_result.status     = mts_pkg::STATUS_EMPTY;
                    n_state             = S_IDLE;
                end else begin
                    n_sum = sum_next;
                    n_j   = r_j + mts_pkg::STATE_BITS'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
        r_from   <= n_from;
        r_to     <= n_to;
        r_rnd    <= n_rnd;
        r_j      <= n_j;
        r_sum    <= n_sum;
        r_target <= n_target;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

FILE: rtl/mts_checker.sv
// Port-level checker for the transition sampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "markov_transition_sampler_defines.svh"
module mts_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire mts_pkg::t_result o_result
);

    // Reset starts the clearing pass, so no result and a busy block follow.
    `MTS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_valid && busy), "result or idle after reset")

    // Every result strobe traces back to a transfer or to work in progress.
    `MTS_ASSERT_RUN(a_valid_cause, i_clk, i_rst_n, o_valid |-> ($past(start) || $past(busy)), "result without a transfer")

    `MTS_ASSERT_RUN(a_status_legal, i_clk, i_rst_n, o_valid |-> (o_result.status <= mts_pkg::STATUS_RANGE), "undefined status code")

    `MTS_ASSERT_RUN(a_err_zero, i_clk, i_rst_n, (o_valid && (o_result.status != mts_pkg::STATUS_OK)) |-> (o_result.next_state == '0), "nonzero state on error")

endmodule

bind markov_transition_sampler mts_checker u_mts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire
